// File: rtl/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types, opcodes and board helpers for the prefilled queens search.
// ----------------------------------------------------------------------------
package pqs_pkg;

  localparam int unsigned BOARD_SIZE = 8;
  localparam int unsigned IDX_W      = $clog2(BOARD_SIZE);
  localparam int unsigned CNT_W      = IDX_W + 1;

  typedef logic [BOARD_SIZE-1:0] row_mask_t;
  typedef row_mask_t [BOARD_SIZE-1:0] board_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLACE = 2'd1,
    OP_SOLVE = 2'd2
  } pqs_op_e;

  // controller to datapath
  typedef struct packed {
    logic wipe_board;
    logic place_fixed;
    logic start_search;
    logic skip_col;
    logic place_queen;
    logic next_row;
    logic step_back;
    logic pop_queen;
    logic mark_found;
    logic mark_fail;
    logic emit_row;
  } pqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic col_done;
    logic col_fixed;
    logic col_zero;
    logic row_end;
    logic cell_free;
    logic out_free;
    logic emit_last;
  } pqs_sts_t;

  function automatic logic col_has_fixed(board_t fixed, logic [IDX_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < int'(BOARD_SIZE); k++) begin
      hit = hit | fixed[k][c];
    end
    return hit;
  endfunction

  // row, column and both diagonals through (r, c) hold no queen of either kind
  function automatic logic cell_free(board_t fixed, board_t player,
                                     logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    row_mask_t occ;
    int        d;
    int        up;
    int        dn;
    logic      ok;
    ok = 1'b1;
    for (int k = 0; k < int'(BOARD_SIZE); k++) begin
      occ = fixed[k] | player[k];
      d   = k - int'(r);
      up  = int'(c) + d;
      dn  = int'(c) - d;
      if (k == int'(r) && occ != '0) ok = 1'b0;
      if (occ[c]) ok = 1'b0;
      if (up >= 0 && up < int'(BOARD_SIZE) && occ[up[IDX_W-1:0]]) ok = 1'b0;
      if (dn >= 0 && dn < int'(BOARD_SIZE) && occ[dn[IDX_W-1:0]]) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// File: rtl/pqs_in_if.sv
// ----------------------------------------------------------------------------
// pqs_in_if
// Command channel: opcode with the square of a fixed piece.
// ----------------------------------------------------------------------------
interface pqs_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [pqs_pkg::IDX_W-1:0]  row;
  logic [pqs_pkg::IDX_W-1:0]  col;

  modport source (output valid, output opcode, output row, output col, input ready);
  modport sink   (input valid, input opcode, input row, input col, output ready);
endinterface

// File: rtl/pqs_out_if.sv
// ----------------------------------------------------------------------------
// pqs_out_if
// Result channel: one board row per transfer.
// ----------------------------------------------------------------------------
interface pqs_out_if;
  logic                           valid;
  logic                           ready;
  logic [pqs_pkg::IDX_W-1:0]      board_row;
  logic [pqs_pkg::BOARD_SIZE-1:0] player_mask;
  logic [pqs_pkg::BOARD_SIZE-1:0] fixed_mask;
  logic                           found;
  logic                           last;

  modport source (output valid, output board_row, output player_mask,
                  output fixed_mask, output found, output last, input ready);
  modport sink   (input valid, input board_row, input player_mask,
                  input fixed_mask, input found, input last, output ready);
endinterface

// File: rtl/prefilled_queens_search.sv
// Clear and place commands give no results. A solve runs a search of column
// checks, row probes and backtrack steps, as many as the fixed pieces call
// for, then gives 8 results through the output register, one per cycle
// while the output channel is not stalled.
// One command is worked at a time; the sequencer takes one only when idle.
// Reset clears both boards, counters and sequencer at once; no clearing pass.
// ----------------------------------------------------------------------------
// prefilled_queens_search
// Eight-queens backtracking search around a board of fixed pieces.
// ----------------------------------------------------------------------------
module prefilled_queens_search (
  input  logic      clk_i,
  input  logic      rst_ni,
  pqs_in_if.sink    in_i,
  pqs_out_if.source out_o
);
  import pqs_pkg::*;

  pqs_cmd_t cmd;
  pqs_sts_t sts;

  pqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pqs_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .row_i  (in_i.row),
    .col_i  (in_i.col),
    .out_o  (out_o)
  );

endmodule

// File: rtl/pqs_datapath.sv
// ----------------------------------------------------------------------------
// pqs_datapath
// Board registers, row stack, search counters, probe logic and the result
// output register.
// ----------------------------------------------------------------------------
module pqs_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pqs_pkg::pqs_cmd_t         cmd_i,
  output pqs_pkg::pqs_sts_t         sts_o,
  input  logic [pqs_pkg::IDX_W-1:0] row_i,
  input  logic [pqs_pkg::IDX_W-1:0] col_i,
  pqs_out_if.source                 out_o
);
  import pqs_pkg::*;

  board_t                  fixed_q, fixed_d;
  board_t                  player_q, player_d;
  logic [IDX_W-1:0]        stack_q [BOARD_SIZE];
  logic [CNT_W-1:0]        col_q, col_d;
  logic [CNT_W-1:0]        row_q, row_d;
  logic                    found_q, found_d;
  logic [IDX_W-1:0]        emit_k_q, emit_k_d;

  logic                    out_valid_q, out_valid_d;
  logic [IDX_W-1:0]        out_row_q;
  row_mask_t               out_player_q;
  row_mask_t               out_fixed_q;
  logic                    out_found_q;
  logic                    out_last_q;

  logic [IDX_W-1:0]        col_idx;
  logic [IDX_W-1:0]        row_idx;
  logic [IDX_W-1:0]        pop_row;

  assign col_idx = col_q[IDX_W-1:0];
  assign row_idx = row_q[IDX_W-1:0];
  assign pop_row = stack_q[col_idx];

  always_comb begin
    fixed_d  = fixed_q;
    player_d = player_q;
    col_d    = col_q;
    row_d    = row_q;
    found_d  = found_q;
    emit_k_d = emit_k_q;
    if (cmd_i.wipe_board) begin
      fixed_d  = '0;
      player_d = '0;
      col_d    = '0;
    end
    if (cmd_i.place_fixed) begin
      fixed_d[row_i][col_i] = 1'b1;
    end
    if (cmd_i.start_search) begin
      player_d = '0;
      col_d    = '0;
      row_d    = '0;
    end
    if (cmd_i.skip_col) begin
      col_d = col_q + CNT_W'(1);
      row_d = '0;
    end
    if (cmd_i.place_queen) begin
      player_d[row_idx][col_idx] = 1'b1;
      col_d = col_q + CNT_W'(1);
      row_d = '0;
    end
    if (cmd_i.next_row) begin
      row_d = row_q + CNT_W'(1);
    end
    if (cmd_i.step_back) begin
      col_d = col_q - CNT_W'(1);
    end
    if (cmd_i.pop_queen) begin
      player_d[pop_row][col_idx] = 1'b0;
      row_d = {1'b0, pop_row} + CNT_W'(1);
    end
    if (cmd_i.mark_found) begin
      found_d  = 1'b1;
      emit_k_d = '0;
    end
    if (cmd_i.mark_fail) begin
      found_d  = 1'b0;
      col_d    = '0;
      emit_k_d = '0;
    end
    if (cmd_i.emit_row) begin
      emit_k_d = emit_k_q + IDX_W'(1);
    end
  end

  assign out_valid_d = cmd_i.emit_row | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_q     <= '0;
      player_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      emit_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fixed_q     <= fixed_d;
      player_q    <= player_d;
      col_q       <= col_d;
      row_q       <= row_d;
      emit_k_q    <= emit_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    if (cmd_i.place_queen) begin
      stack_q[col_idx] <= row_idx;
    end
    if (cmd_i.emit_row) begin
      out_row_q    <= emit_k_q;
      out_player_q <= player_q[emit_k_q];
      out_fixed_q  <= fixed_q[emit_k_q];
      out_found_q  <= found_q;
      out_last_q   <= (emit_k_q == IDX_W'(BOARD_SIZE - 1));
    end
  end

  assign sts_o.col_done  = (col_q == CNT_W'(BOARD_SIZE));
  assign sts_o.col_fixed = col_has_fixed(fixed_q, col_idx);
  assign sts_o.col_zero  = (col_q == '0);
  assign sts_o.row_end   = (row_q == CNT_W'(BOARD_SIZE));
  assign sts_o.cell_free = cell_free(fixed_q, player_q, row_idx, col_idx);
  assign sts_o.out_free  = ~out_valid_q | out_o.ready;
  assign sts_o.emit_last = (emit_k_q == IDX_W'(BOARD_SIZE - 1));

  assign out_o.valid       = out_valid_q;
  assign out_o.board_row   = out_row_q;
  assign out_o.player_mask = out_player_q;
  assign out_o.fixed_mask  = out_fixed_q;
  assign out_o.found       = out_found_q;
  assign out_o.last        = out_last_q;

`ifndef SYNTHESIS
  a_place_adds_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place_queen |=> $countones(player_q) == $past($countones(player_q)) + 1)
    else $error("placing a queen did not add exactly one queen");

  a_place_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place_queen |-> !sts_o.col_fixed && sts_o.cell_free && !sts_o.row_end)
    else $error("queen placed on an attacked square or fixed column");

  a_last_on_final_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.board_row == IDX_W'(BOARD_SIZE - 1))
    else $error("last flag on a row other than the final one");

  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.found |-> out_o.player_mask == '0)
    else $error("failed search left queens on the board");
`endif

endmodule

// File: rtl/pqs_ctrl.sv
// ----------------------------------------------------------------------------
// pqs_ctrl
// Sequencer for command decode, the backtracking search and row emission.
// ----------------------------------------------------------------------------
module pqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        opcode_i,
  output logic              in_ready_o,
  input  pqs_pkg::pqs_sts_t sts_i,
  output pqs_pkg::pqs_cmd_t cmd_o
);
  import pqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL,
    S_PROBE,
    S_BACK,
    S_BACK_TEST,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_CLEAR: cmd_o.wipe_board = 1'b1;
            OP_PLACE: cmd_o.place_fixed = 1'b1;
            OP_SOLVE: begin
              cmd_o.start_search = 1'b1;
              state_d            = S_COL;
            end
            default: ;
          endcase
        end
      end
      S_COL: begin
        if (sts_i.col_done) begin
          cmd_o.mark_found = 1'b1;
          state_d          = S_EMIT;
        end else if (sts_i.col_fixed) begin
          cmd_o.skip_col = 1'b1;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.row_end) begin
          state_d = S_BACK;
        end else if (sts_i.cell_free) begin
          cmd_o.place_queen = 1'b1;
          state_d           = S_COL;
        end else begin
          cmd_o.next_row = 1'b1;
        end
      end
      S_BACK: begin
        // nothing left to undo: no solution
        if (sts_i.col_zero) begin
          cmd_o.mark_fail = 1'b1;
          state_d         = S_EMIT;
        end else begin
          cmd_o.step_back = 1'b1;
          state_d         = S_BACK_TEST;
        end
      end
      S_BACK_TEST: begin
        if (sts_i.col_fixed) begin
          state_d = S_BACK;
        end else begin
          cmd_o.pop_queen = 1'b1;
          state_d         = S_PROBE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_row = 1'b1;
          if (sts_i.emit_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, place and solve commands into the queens search and checks
// every board row that comes back against a search of its own, with random
// idling on both channels, a long result stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pqs_pkg::*;

  localparam int          N           = BOARD_SIZE;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          CALM_ITEMS  = 20;
  localparam int          STALL_AFTER = 40;
  localparam int          STALL_LEN   = 300;
  localparam int          IDLE_LIMIT  = 100000;
  localparam int          TAIL_CYCLES = 40;

  typedef struct {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    bit               drain;
  } cmd_t;

  typedef struct {
    logic [IDX_W-1:0] board_row;
    row_mask_t        player_mask;
    row_mask_t        fixed_mask;
    logic             found;
    logic             last;
  } row_result_t;

  logic clk_i;
  logic rst_ni;

  pqs_in_if  cmd_if ();
  pqs_out_if row_if ();

  prefilled_queens_search i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (row_if)
  );

  cmd_t        pending [$];
  row_result_t board_rows_q [$];
  row_mask_t   fixed_rows [N];
  row_mask_t   queen_rows [N];

  int errors      = 0;
  int cmds_taken  = 0;
  int send_gap    = 0;
  int sink_gap    = 0;
  int stall_left  = 0;
  bit stall_done  = 0;
  int idle_cycles = 0;
  bit cmd_xfer;
  bit calm;

  assign calm = (pending.size() < CALM_ITEMS);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit column_pinned(int c);
    for (int k = 0; k < N; k++) begin
      if (fixed_rows[k][c]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // no queen of either kind on the same row, column or diagonal as (r, c)
  function automatic bit square_open(int r, int c);
    for (int k = 0; k < N; k++) begin
      for (int j = 0; j < N; j++) begin
        if ((fixed_rows[k][j] || queen_rows[k][j]) &&
            (k == r || j == c || (k - r) == (j - c) || (k - r) == (c - j)))
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit solve_board();
    int c;
    int r;
    int start;
    int pick [N];
    for (int k = 0; k < N; k++) queen_rows[k] = '0;
    c     = 0;
    start = 0;
    while (c < N) begin
      if (column_pinned(c)) begin
        c++;
        start = 0;
      end else begin
        r = start;
        while (r < N && !square_open(r, c)) r++;
        if (r < N) begin
          queen_rows[r][c] = 1'b1;
          pick[c]          = r;
          c++;
          start = 0;
        end else begin
          // back up to the last column the search filled
          c--;
          while (c >= 0 && column_pinned(c)) c--;
          if (c < 0) return 1'b0;
          queen_rows[pick[c]][c] = 1'b0;
          start = pick[c] + 1;
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic apply_command(input logic [1:0] op, input int row, input int col);
    bit          ok;
    row_result_t res;
    case (op)
      OP_CLEAR: begin
        for (int k = 0; k < N; k++) begin
          fixed_rows[k] = '0;
          queen_rows[k] = '0;
        end
      end
      OP_PLACE: fixed_rows[row][col] = 1'b1;
      OP_SOLVE: begin
        ok = solve_board();
        for (int k = 0; k < N; k++) begin
          res.board_row   = k[IDX_W-1:0];
          res.player_mask = queen_rows[k];
          res.fixed_mask  = fixed_rows[k];
          res.found       = ok;
          res.last        = (k == N - 1);
          board_rows_q.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_row(input row_result_t want);
    if (row_if.board_row !== want.board_row)
      report_mismatch("board_row", row_if.board_row, want.board_row);
    if (row_if.player_mask !== want.player_mask)
      report_mismatch("player_mask", row_if.player_mask, want.player_mask);
    if (row_if.fixed_mask !== want.fixed_mask)
      report_mismatch("fixed_mask", row_if.fixed_mask, want.fixed_mask);
    if (row_if.found !== want.found)
      report_mismatch("found", row_if.found, want.found);
    if (row_if.last !== want.last)
      report_mismatch("last", row_if.last, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_xfer <= 1'b0;
    end else begin
      cmd_xfer <= cmd_if.valid && cmd_if.ready;
      if (row_if.valid && row_if.ready) begin
        if (board_rows_q.size() == 0) begin
          report_mismatch("unexpected row transfer, board_row", row_if.board_row, -1);
        end else begin
          check_row(board_rows_q[0]);
          board_rows_q.delete(0);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        apply_command(cmd_if.opcode, cmd_if.row, cmd_if.col);
        cmds_taken++;
      end
    end
  end

  // ---------------------------------------------------------------- driving

  always @(negedge clk_i) begin
    logic v;
    v = cmd_if.valid;
    if (cmd_xfer) begin
      pending.delete(0);
      v = 1'b0;
    end
    if (rst_ni && !v) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 12) - 1;
      end else if (pending.size() > 0 &&
                   !(pending[0].drain && board_rows_q.size() != 0)) begin
        v = 1'b1;
      end
    end
    if (v) begin
      cmd_if.opcode <= pending[0].opcode;
      cmd_if.row    <= pending[0].row;
      cmd_if.col    <= pending[0].col;
    end
    cmd_if.valid <= v;
  end

  always @(negedge clk_i) begin
    logic r;
    if (!stall_done && cmds_taken >= STALL_AFTER) begin
      stall_done = 1'b1;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      r = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      r = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 12) - 1;
      r = 1'b0;
    end else begin
      r = 1'b1;
    end
    row_if.ready <= r;
  end

  // a solve gives no transfer on either side while it searches; IDLE_LIMIT allows for it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (row_if.valid && row_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_cmd(input logic [1:0] op, input int row, input int col,
                         input bit drain = 1'b0);
    cmd_t cmd;
    cmd.opcode = op;
    cmd.row    = row[IDX_W-1:0];
    cmd.col    = col[IDX_W-1:0];
    cmd.drain  = drain;
    pending.push_back(cmd);
  endtask

  // known eight-queens placements, row of column c at bits [3c +: 3]
  function automatic logic [3*N-1:0] solution_rows(int s);
    case (s)
      0:       return {3'd3, 3'd1, 3'd6, 3'd2, 3'd5, 3'd7, 3'd4, 3'd0};
      1:       return {3'd4, 3'd1, 3'd3, 3'd6, 3'd2, 3'd7, 3'd5, 3'd0};
      2:       return {3'd4, 3'd6, 3'd0, 3'd2, 3'd7, 3'd5, 3'd3, 3'd1};
      default: return {3'd5, 3'd3, 3'd6, 3'd0, 3'd7, 3'd1, 3'd4, 3'd2};
    endcase
  endfunction

  task automatic build_stimulus();
    logic [3*N-1:0] sol;
    bit             flip_r;
    bit             flip_c;
    int             kind;
    int             count;
    int             r;
    // directed: empty board straight out of reset, ignored opcode
    add_cmd(OP_SOLVE, 0, 0);
    add_cmd(OP_UNUSED, 7, 7);
    // corner pieces that attack each other, then a repeated solve
    add_cmd(OP_PLACE, 0, 0);
    add_cmd(OP_PLACE, 7, 7);
    add_cmd(OP_PLACE, 0, 7);
    add_cmd(OP_PLACE, 7, 0);
    add_cmd(OP_SOLVE, 0, 0);
    add_cmd(OP_SOLVE, 0, 0);
    // four pieces stacked in column 0 leave no room: no solution
    add_cmd(OP_CLEAR, 7, 7);
    add_cmd(OP_PLACE, 0, 0);
    add_cmd(OP_PLACE, 2, 0);
    add_cmd(OP_PLACE, 4, 0);
    add_cmd(OP_PLACE, 6, 0);
    add_cmd(OP_SOLVE, 0, 0);
    // every column fixed, one piece placed twice
    add_cmd(OP_CLEAR, 0, 0);
    sol = solution_rows(3);
    for (int c = 0; c < N; c++) add_cmd(OP_PLACE, sol[3*c +: 3], c);
    add_cmd(OP_PLACE, sol[3*7 +: 3], 7);
    add_cmd(OP_SOLVE, 0, 0);

    count = 0;
    while (count < 115) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // subset of a real placement as fixed pieces: always solvable
        sol    = solution_rows($urandom_range(0, 3));
        flip_r = $urandom_range(0, 1);
        flip_c = $urandom_range(0, 1);
        add_cmd(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7),
                count == 0 || $urandom_range(0, 7) == 0);
        count++;
        for (int c = 0; c < N; c++) begin
          if ($urandom_range(0, 2) == 0) begin
            r = sol[3*c +: 3];
            add_cmd(OP_PLACE, flip_r ? N - 1 - r : r, flip_c ? N - 1 - c : c);
            count++;
          end
        end
        add_cmd(OP_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7));
        count++;
        if ($urandom_range(0, 4) == 0) begin
          add_cmd(OP_SOLVE, 0, 0);
          count++;
        end
      end else if (kind < 9) begin
        // random pieces, possibly on top of the previous board
        if ($urandom_range(0, 1) == 1) begin
          add_cmd(OP_CLEAR, 0, 0);
          count++;
        end
        repeat ($urandom_range(1, 4)) begin
          add_cmd(OP_PLACE, $urandom_range(0, 7), $urandom_range(0, 7));
          count++;
        end
        add_cmd(OP_SOLVE, 0, 0);
        count++;
      end else if ($urandom_range(0, 1) == 1) begin
        add_cmd(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7));
      end else begin
        add_cmd(OP_SOLVE, 0, 0);
        count++;
      end
    end
  endtask

  initial begin
    cmd_if.valid  = 1'b0;
    cmd_if.opcode = OP_CLEAR;
    cmd_if.row    = '0;
    cmd_if.col    = '0;
    row_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    for (int k = 0; k < N; k++) begin
      fixed_rows[k] = '0;
      queen_rows[k] = '0;
    end
    build_stimulus();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending.size() != 0 || board_rows_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
